// ----- hw/rtl/dtfsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dtfsm_pkg
// Shared types, constants and the drag table of the flap servo map.
// ----------------------------------------------------------------------------
package dtfsm_pkg;

  localparam int unsigned TablePointsDefault = 10;
  localparam int unsigned CdW      = 16;
  localparam int unsigned FlapW    = 16;
  localparam int unsigned ServoW   = 18;
  localparam int unsigned StatW    = 2;
  localparam int unsigned StepQ10  = 5120;
  localparam int unsigned ServoOffset = 69776;
  localparam int unsigned SqrtScale   = 106276;
  localparam int unsigned NumW     = 29;   // 5120 * 65535 < 2^29
  localparam int unsigned DenW     = 17;   // 2 * den
  localparam int unsigned QuoW     = 14;   // rounded quotient <= 5120
  localparam int unsigned RadW     = 33;   // 46080 * 106276 < 2^33
  localparam int unsigned RootW    = 17;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [StatW-1:0] {
    StatInterp = 2'd0,
    StatBelow  = 2'd1,
    StatAbove  = 2'd2
  } stat_e;

  typedef struct packed {
    logic [NumW-1:0]  num2;   // 2*num + den
    logic [DenW-1:0]  den2;   // 2*den, zero when no division
    logic [FlapW-1:0] base;
    logic             active;
    stat_e            stat;
  } job_t;

  function automatic logic [CdW-1:0] cd_point(input int unsigned idx);
    logic [CdW-1:0] v;
    unique case (idx)
      0: v = 16'd10830;
      1: v = 16'd10830;
      2: v = 16'd12517;
      3: v = 16'd14377;
      4: v = 16'd17072;
      5: v = 16'd19120;
      6: v = 16'd21660;
      7: v = 16'd24330;
      8: v = 16'd26706;
      default: v = 16'd30048;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/dtfsm_front.sv -----
// ----------------------------------------------------------------------------
// dtfsm_front
// Classify a coefficient against the table and form the division terms.
// ----------------------------------------------------------------------------
module dtfsm_front #(
  parameter int unsigned TablePoints = dtfsm_pkg::TablePointsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [dtfsm_pkg::CdW-1:0] target_cd_i,
  input  logic                      active_flight_i,
  output logic                      valid_o,
  output dtfsm_pkg::job_t           job_o
);
  import dtfsm_pkg::*;

  localparam logic [FlapW-1:0] FullQ10 = FlapW'((TablePoints - 1) * StepQ10);

  job_t job_d, job_q;
  logic valid_q;

  always_comb begin
    logic found;
    logic [CdW-1:0] lo, hi;
    logic [DenW-1:0] den;
    logic [NumW-1:0] num;
    found = 1'b0;
    lo = '0;
    hi = '0;
    den = '0;
    num = '0;
    job_d = '0;
    job_d.active = active_flight_i;
    job_d.stat = StatInterp;
    if (active_flight_i) begin
      if (target_cd_i < cd_point(0)) begin
        job_d.stat = StatBelow;
      end else if (target_cd_i > cd_point(TablePoints - 1)) begin
        job_d.stat = StatAbove;
        job_d.base = FullQ10;
      end else begin
        for (int i = 0; i < TablePoints - 1; i++) begin
          lo = cd_point(i);
          hi = cd_point(i + 1);
          if (!found && lo <= target_cd_i && target_cd_i <= hi) begin
            found = 1'b1;
            job_d.base = FlapW'(i * StepQ10);
            if (hi != lo) begin
              den = DenW'(hi - lo);
              num = NumW'(StepQ10) * NumW'(target_cd_i - lo);
              job_d.den2 = DenW'(den << 1);
              job_d.num2 = NumW'(num << 1) + NumW'(den);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      job_q <= job_d;
    end
  end

  assign valid_o = valid_q;
  assign job_o   = job_q;

endmodule

// ----- hw/rtl/dtfsm_queue.sv -----
// ----------------------------------------------------------------------------
// dtfsm_queue
// Small FIFO that reports its fill level.
// ----------------------------------------------------------------------------
module dtfsm_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [Width-1:0]               data_i,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic [$clog2(Depth + 1)-1:0]   level_o,
  output logic [Width-1:0]               data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i) rd_q <= nxt(rd_q);
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign empty_o = (cnt_q == '0);
  assign level_o = cnt_q;
  assign data_o  = mem_q[rd_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(Depth)) |-> (!push_i || pop_i))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count");
`endif

endmodule

// ----- hw/rtl/dtfsm_back.sv -----
// ----------------------------------------------------------------------------
// dtfsm_back
// Pipelined restoring divide, pipelined square root and servo offset.
// ----------------------------------------------------------------------------
module dtfsm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  dtfsm_pkg::job_t              job_i,
  output logic                         valid_o,
  output logic [dtfsm_pkg::FlapW-1:0]  flap_angle_o,
  output logic [dtfsm_pkg::ServoW-1:0] servo_target_o,
  output logic [dtfsm_pkg::StatW-1:0]  stat_o
);
  import dtfsm_pkg::*;

  // divide: one quotient bit per stage
  localparam int unsigned DivS = QuoW;
  localparam int unsigned SqS  = RootW;
  localparam int unsigned RemW = DenW + 1;

  typedef struct packed {
    logic             active;
    logic [StatW-1:0] stat;
    logic [FlapW-1:0] base;
    logic [DenW-1:0]  den2;
  } side_t;

  logic  dv_q [DivS+1];
  side_t ds_q [DivS+1];
  logic [NumW-1:0] dn_q [DivS+1];   // shifting numerator
  logic [RemW-1:0] dr_q [DivS+1];
  logic [QuoW-1:0] dq_q [DivS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv_i) begin
      dv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ds_q[0] <= '{active: job_i.active, stat: job_i.stat, base: job_i.base,
                   den2: job_i.den2};
      dn_q[0] <= NumW'(job_i.num2 << (NumW - QuoW));
      dr_q[0] <= RemW'(job_i.num2 >> QuoW);
      dq_q[0] <= '0;
    end
  end

  // remainder seed holds high bits; quotient < 2^QuoW when den2 > 0
  for (genvar s = 0; s < DivS; s++) begin : g_div
    logic [RemW-1:0] tr;
    logic ge;
    assign tr = {dr_q[s][RemW-2:0], dn_q[s][NumW-1]};
    assign ge = (ds_q[s].den2 != '0) && (tr >= RemW'(ds_q[s].den2));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        dv_q[s+1] <= dv_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ds_q[s+1] <= ds_q[s];
        dn_q[s+1] <= NumW'(dn_q[s] << 1);
        dr_q[s+1] <= ge ? tr - RemW'(ds_q[s].den2) : tr;
        dq_q[s+1] <= {dq_q[s][QuoW-2:0], ge};
      end
    end
  end

  // flap and radicand
  logic             fv_q;
  logic             fa_q;
  logic [StatW-1:0] fs_q;
  logic [FlapW-1:0] ff_q;
  logic [FlapW-1:0] flap;
  assign flap = ds_q[DivS].base + FlapW'(dq_q[DivS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else if (adv_i) fv_q <= dv_q[DivS];
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fa_q <= ds_q[DivS].active;
      fs_q <= ds_q[DivS].stat;
      ff_q <= ds_q[DivS].active ? flap : '0;
    end
  end

  logic [RadW-1:0] rad;
  assign rad = RadW'(FlapW'(46080) - ff_q) * RadW'(SqrtScale);

  // square root: one root bit per stage, remainder carries rounding
  localparam int unsigned SRemW = RootW + 2;
  logic sv_q [SqS+1];
  logic sa_q [SqS+1];
  logic [StatW-1:0] ss_q [SqS+1];
  logic [FlapW-1:0] sf_q [SqS+1];
  logic [RadW+1:0]  sx_q [SqS+1];
  logic [SRemW-1:0] sr_q [SqS+1];
  logic [RootW-1:0] sq_q [SqS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (adv_i) sv_q[0] <= fv_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sa_q[0] <= fa_q;
      ss_q[0] <= fs_q;
      sf_q[0] <= ff_q;
      sx_q[0] <= {1'b0, rad, 1'b0};
      sr_q[0] <= '0;
      sq_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < SqS; s++) begin : g_sqrt
    logic [SRemW-1:0] tr, tt;
    logic ge;
    assign tr = {sr_q[s][SRemW-3:0], sx_q[s][RadW+1:RadW]};
    assign tt = {sq_q[s], 2'b01};
    assign ge = tr >= tt;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[s+1] <= 1'b0;
      else if (adv_i) sv_q[s+1] <= sv_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sa_q[s+1] <= sa_q[s];
        ss_q[s+1] <= ss_q[s];
        sf_q[s+1] <= sf_q[s];
        sx_q[s+1] <= (RadW+2)'(sx_q[s] << 2);
        sr_q[s+1] <= ge ? tr - tt : tr;
        sq_q[s+1] <= {sq_q[s][RootW-2:0], ge};
      end
    end
  end

  // remainder = x - r*r; round up when it exceeds r
  logic [RootW-1:0] root;
  logic [ServoW-1:0] servo;
  assign root  = sq_q[SqS] + RootW'(SRemW'(sq_q[SqS]) < sr_q[SqS]);
  assign servo = ServoW'(root) - ServoW'(ServoOffset);

  logic ov_q;
  logic [FlapW-1:0] of_q;
  logic [ServoW-1:0] os_q;
  logic [StatW-1:0] ost_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv_i) ov_q <= sv_q[SqS];
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      of_q  <= sf_q[SqS];
      os_q  <= sa_q[SqS] ? servo : '0;
      ost_q <= ss_q[SqS];
    end
  end

  assign valid_o        = ov_q;
  assign flap_angle_o   = of_q;
  assign servo_target_o = os_q;
  assign stat_o         = ost_q;

endmodule

// ----- hw/rtl/drag_to_flap_servo_map.sv -----
// ----------------------------------------------------------------------------
// drag_to_flap_servo_map
// Pipeline: front register, job queue, back (14 divide, 17 square root and 4
// further register stages), result queue.
// Throughput: one request per cycle while pop keeps up; when the result queue
// fills the back stalls, and full rises once the job queue has no room left.
// Reset: asynchronous, clears all valid flags, FIFO pointers and fill levels.
// ----------------------------------------------------------------------------
module drag_to_flap_servo_map #(
  parameter int unsigned TablePoints = dtfsm_pkg::TablePointsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [dtfsm_pkg::CdW-1:0]    target_cd_i,
  input  logic                         active_flight_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [dtfsm_pkg::FlapW-1:0]  flap_angle_o,
  output logic [dtfsm_pkg::ServoW-1:0] servo_target_o,
  output logic [dtfsm_pkg::StatW-1:0]  clamp_status_o
);
  import dtfsm_pkg::*;

  localparam int unsigned OutDepth = 4;
  localparam int unsigned JobCntW = $clog2(QueueDepth + 1);
  localparam int unsigned OutCntW = $clog2(OutDepth + 1);
  localparam int unsigned OutW = FlapW + ServoW + StatW;

  logic acc, pop_ok, adv;
  logic fv, qv, q_pop, bv, q_empty;
  job_t fj, qj;
  logic [JobCntW-1:0] jq_level;
  logic [OutCntW-1:0] oq_level;
  logic [FlapW-1:0] bf;
  logic [ServoW-1:0] bs;
  logic [StatW-1:0] bst;
  logic [OutW-1:0] od;

  assign acc    = push && !full;
  assign pop_ok = pop && !empty;
  assign full   = (jq_level + JobCntW'(fv)) >= JobCntW'(QueueDepth);
  assign adv    = (oq_level != OutCntW'(OutDepth));

  dtfsm_front #(.TablePoints(TablePoints)) u_front (
    .clk_i, .rst_ni, .valid_i(acc), .target_cd_i, .active_flight_i,
    .valid_o(fv), .job_o(fj)
  );

  dtfsm_queue #(.Width($bits(job_t)), .Depth(QueueDepth)) u_jobq (
    .clk_i, .rst_ni, .push_i(fv), .data_i(fj), .pop_i(q_pop),
    .empty_o(q_empty), .level_o(jq_level), .data_o(qj)
  );
  assign qv    = !q_empty;
  assign q_pop = qv && adv;

  dtfsm_back u_back (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(qv), .job_i(qj), .valid_o(bv),
    .flap_angle_o(bf), .servo_target_o(bs), .stat_o(bst)
  );

  dtfsm_queue #(.Width(OutW), .Depth(OutDepth)) u_outq (
    .clk_i, .rst_ni, .push_i(bv && adv), .data_i({bf, bs, bst}), .pop_i(pop_ok),
    .empty_o(empty), .level_o(oq_level), .data_o(od)
  );

  assign {flap_angle_o, servo_target_o, clamp_status_o} = od;

`ifndef SYNTHESIS
  a_job_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (jq_level + JobCntW'(fv)) <= JobCntW'(QueueDepth))
    else $error("job queue overrun");
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_level <= OutCntW'(OutDepth))
    else $error("result queue overrun");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (clamp_status_o != 2'd3))
    else $error("bad status");
`endif

endmodule
